// ===== hdl/pic_pkg.sv =====
// Shared types and constants for the point-in-polygon test block.
package pic_pkg;

	localparam int TOL_W    = 20;
	localparam int VTOTAL_W = 5;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_TEST   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} pic_state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} pic_cell_ctl_t;

	typedef struct packed {
		logic valid;
		logic on_edge;
		logic crossing;
	} pic_edge_res_t;

endpackage

// ===== hdl/pic_in_if.sv =====
// Request channel: one vertex append or one point test.
interface pic_in_if #(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;

	modport source (output valid, output op, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input op, input x_coord, input y_coord, output ready);
endinterface

// ===== hdl/pic_out_if.sv =====
// Result channel: one result for every request.
interface pic_out_if;
	logic       valid;
	logic       ready;
	logic       inside_res;
	logic       on_boundary;
	logic       append_refused;
	logic [4:0] vertex_total;

	modport source (output valid, output inside_res, output on_boundary,
		output append_refused, output vertex_total, input ready);
	modport sink   (input valid, input inside_res, input on_boundary,
		input append_refused, input vertex_total, output ready);
endinterface

// ===== hdl/point_in_polygon_test_top.sv =====
// An append goes from ST_IDLE to ST_DONE and then to the output register; a test runs
// ST_RUN, the ring rotating one edge per cycle into a four-stage edge pipeline, then
// ST_DRAIN until that pipeline is empty, then ST_DONE (an empty store skips ST_RUN).
// One request at a time: a new one is taken only in ST_IDLE; a waiting result holds back
// the request after next.
// Reset clears the vertex count, the tolerance and all control; vertex cells are not reset.
// Top level of the point-in-polygon crossing-number test block.
module point_in_polygon_test_top #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_WIDTH  = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pic_in_if.sink                    req,
	pic_out_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [pic_pkg::TOL_W-1:0] cfg_data
);
	import pic_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W = $clog2(MAX_VERTICES);

	pic_state_t state_q, state_d;

	logic [TOL_W-1:0]              tol_q;
	logic [CNT_W-1:0]              count_q;
	logic [IDX_W-1:0]              step_q;
	logic signed [COORD_WIDTH-1:0] px_q, py_q;
	logic                          parity_q, onb_q, refused_q, op_q;

	logic                          out_valid_q;
	logic                          out_inside_q, out_onb_q, out_refused_q;
	logic [VTOTAL_W-1:0]           out_total_q;

	logic accept, full, last, slot_free, launch, do_out;
	logic append_ok;

	logic signed [COORD_WIDTH-1:0] cell_x [MAX_VERTICES];
	logic signed [COORD_WIDTH-1:0] cell_y [MAX_VERTICES];
	logic signed [COORD_WIDTH-1:0] edge_bx, edge_by;

	pic_edge_res_t edge_res;
	logic          edge_busy;

	assign full      = (count_q == CNT_W'(MAX_VERTICES));
	assign last      = (CNT_W'(step_q) == count_q - CNT_W'(1));
	assign slot_free = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign append_ok = accept && (req.op == OP_APPEND) && !full;

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		launch    = 1'b0;
		do_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.op == OP_TEST && count_q != '0) begin
						state_d = ST_RUN;
					end else if (req.op == OP_TEST) begin
						state_d = ST_DRAIN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_RUN: begin
				launch = 1'b1;
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!edge_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					do_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= '0;
			count_q     <= '0;
			step_q      <= '0;
			parity_q    <= 1'b0;
			onb_q       <= 1'b0;
			refused_q   <= 1'b0;
			op_q        <= OP_APPEND;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_data;
			end
			if (accept) begin
				op_q      <= req.op;
				refused_q <= (req.op == OP_APPEND) && full;
				step_q    <= '0;
				parity_q  <= 1'b0;
				onb_q     <= 1'b0;
			end
			if (append_ok) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (launch) begin
				step_q <= step_q + IDX_W'(1);
			end
			// Once a boundary hit is seen the rest of the walk no longer matters.
			if (edge_res.valid && !onb_q) begin
				if (edge_res.on_edge) begin
					onb_q <= 1'b1;
				end else if (edge_res.crossing) begin
					parity_q <= ~parity_q;
				end
			end
			if (do_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= req.x_coord;
			py_q <= req.y_coord;
		end
		if (do_out) begin
			out_inside_q  <= (op_q == OP_TEST) && (onb_q || parity_q);
			out_onb_q     <= (op_q == OP_TEST) && onb_q;
			out_refused_q <= (op_q == OP_APPEND) && refused_q;
			out_total_q   <= VTOTAL_W'(count_q);
		end
	end

	// The ring spans the held vertices only: the last held cell takes from cell 0,
	// so after one full walk every vertex is back in its own cell.
	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		pic_cell_ctl_t                 ctl;
		logic signed [COORD_WIDTH-1:0] sx, sy;

		assign ctl.load  = append_ok && (count_q[IDX_W-1:0] == IDX_W'(i));
		assign ctl.shift = launch;

		if (i == MAX_VERTICES - 1) begin : g_tail
			assign sx = cell_x[0];
			assign sy = cell_y[0];
		end else begin : g_body
			assign sx = (CNT_W'(i) == count_q - CNT_W'(1)) ? cell_x[0] : cell_x[i+1];
			assign sy = (CNT_W'(i) == count_q - CNT_W'(1)) ? cell_y[0] : cell_y[i+1];
		end

		pic_cell #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.load_x  (req.x_coord),
			.load_y  (req.y_coord),
			.shift_x (sx),
			.shift_y (sy),
			.x       (cell_x[i]),
			.y       (cell_y[i])
		);
	end

	// A single vertex closes on itself.
	assign edge_bx = (count_q == CNT_W'(1)) ? cell_x[0] : cell_x[1];
	assign edge_by = (count_q == CNT_W'(1)) ? cell_y[0] : cell_y[1];

	pic_edge_unit #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.launch (launch),
		.ax     (cell_x[0]),
		.ay     (cell_y[0]),
		.bx     (edge_bx),
		.by     (edge_by),
		.px     (px_q),
		.py     (py_q),
		.tol    (tol_q),
		.res    (edge_res),
		.busy   (edge_busy)
	);

	assign rsp.valid          = out_valid_q;
	assign rsp.inside_res     = out_inside_q;
	assign rsp.on_boundary    = out_onb_q;
	assign rsp.append_refused = out_refused_q;
	assign rsp.vertex_total   = out_total_q;
endmodule

// ===== hdl/pic_cell.sv =====
// One vertex cell of the rotating polygon ring.
module pic_cell #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  pic_pkg::pic_cell_ctl_t        ctl,
	input  logic signed [COORD_WIDTH-1:0] load_x,
	input  logic signed [COORD_WIDTH-1:0] load_y,
	input  logic signed [COORD_WIDTH-1:0] shift_x,
	input  logic signed [COORD_WIDTH-1:0] shift_y,
	output logic signed [COORD_WIDTH-1:0] x,
	output logic signed [COORD_WIDTH-1:0] y
);
	import pic_pkg::*;

	logic signed [COORD_WIDTH-1:0] x_q;
	logic signed [COORD_WIDTH-1:0] y_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= load_x;
			y_q <= load_y;
		end else if (ctl.shift) begin
			x_q <= shift_x;
			y_q <= shift_y;
		end
	end

	assign x = x_q;
	assign y = y_q;
endmodule

// ===== hdl/pic_edge_unit.sv =====
// Pipelined edge evaluation: span check, cross product and tolerance compare.
module pic_edge_unit #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          launch,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic [pic_pkg::TOL_W-1:0]     tol,
	output pic_pkg::pic_edge_res_t        res,
	output logic                          busy
);
	import pic_pkg::*;

	localparam int DW  = COORD_WIDTH + 1;
	localparam int PW  = 2 * DW;
	localparam int CPW = PW + 1;
	localparam int TW  = ((CPW > TOL_W + 1) ? CPW : TOL_W + 1) + 1;

	logic signed [COORD_WIDTH-1:0] lx, ly, hx, hy;
	logic                          qual;

	logic                 v_s1, v_s2, v_s3;
	logic signed [DW-1:0] d1_s1, d2_s1, d3_s1, d4_s1;
	logic signed [PW-1:0] m1_s2, m2_s2;
	logic signed [CPW-1:0] cp_s3;
	pic_edge_res_t        res_s4;

	logic signed [TW-1:0] cp_ext, tol_ext;

	// Order the edge so that its first end has the lower y.
	always_comb begin
		if (ay > by) begin
			lx = bx;
			ly = by;
			hx = ax;
			hy = ay;
		end else begin
			lx = ax;
			ly = ay;
			hx = bx;
			hy = by;
		end
		qual = (ly <= py) && (hy > py);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			res_s4 <= '0;
		end else begin
			v_s1         <= launch && qual;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			res_s4.valid <= v_s3;
			res_s4.on_edge  <= (cp_ext <= tol_ext) && (cp_ext >= -tol_ext);
			res_s4.crossing <= cp_ext > tol_ext;
		end
	end

	always_ff @(posedge clk) begin
		d1_s1 <= DW'(px) - DW'(lx);
		d2_s1 <= DW'(hy) - DW'(ly);
		d3_s1 <= DW'(hx) - DW'(lx);
		d4_s1 <= DW'(py) - DW'(ly);
		m1_s2 <= PW'(d1_s1) * PW'(d2_s1);
		m2_s2 <= PW'(d3_s1) * PW'(d4_s1);
		cp_s3 <= CPW'(m1_s2) - CPW'(m2_s2);
	end

	assign cp_ext  = TW'(cp_s3);
	assign tol_ext = TW'(signed'({1'b0, tol}));

	assign res  = res_s4;
	assign busy = v_s1 || v_s2 || v_s3 || res_s4.valid;
endmodule
